// ----- hw/rtl/hcbp_pkg.sv -----
// hcbp_pkg: request and result types and command codes for the code bit packer
// no dependencies
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int CODE_W = 32;
  localparam int ACC_W  = 7;
  localparam int CNT_W  = 3;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [6:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [5:0]        code_len;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } res_t;

endpackage

// ----- hw/rtl/hcbp_code_table.sv -----
// hcbp_code_table: per-symbol code word and length store with registered read
// entries not written since reset read as an empty code; depends on nothing
`timescale 1ns / 1ps

module hcbp_code_table #(
  parameter int DEPTH   = 128,
  parameter int IDX_W   = 7,
  parameter int BITS_W  = 32,
  parameter int LEN_W   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [BITS_W-1:0] wr_bits,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              rd_en,
  input  logic              rd_ok,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [BITS_W-1:0] rd_bits,
  output logic [LEN_W-1:0]  rd_len
);

  logic [BITS_W-1:0] mem_bits [DEPTH];
  logic [LEN_W-1:0]  mem_len  [DEPTH];
  logic [DEPTH-1:0]  entry_vld;
  logic [BITS_W-1:0] bits_q;
  logic [LEN_W-1:0]  len_q;
  logic              hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_bits[wr_idx] <= wr_bits;
      mem_len[wr_idx]  <= wr_len;
    end
    if (rd_en && rd_ok) begin
      bits_q <= mem_bits[rd_idx];
      len_q  <= mem_len[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      hit       <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        hit <= rd_ok && entry_vld[rd_idx];
      end
    end
  end

  assign rd_bits = hit ? bits_q : '0;
  assign rd_len  = hit ? len_q : '0;

endmodule

// ----- hw/rtl/huffman_code_bit_packer.sv -----
// huffman_code_bit_packer: msb-first code packer, one byte per result request
// a request's table read is registered; its bytes then load into the byte buffer for the port
// throughput: one request per cycle while cmd_stall is low; an item with n bytes holds the byte port
// until all n are taken, so the byte port sets the rate: up to four bytes per encoded symbol, five for a finish
// reset: synchronous; code table reads as empty and the accumulator clears at once
// depends on hcbp_pkg and hcbp_code_table
`timescale 1ns / 1ps

module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT = 128,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  hcbp_pkg::req_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output hcbp_pkg::res_t res
);

  localparam int CODE_W    = hcbp_pkg::CODE_W;
  localparam int ACC_W     = hcbp_pkg::ACC_W;
  localparam int CNT_W     = hcbp_pkg::CNT_W;
  localparam int IDX_W     = $clog2(SYMBOL_COUNT);
  localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
  localparam int BITS_W    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int MAX_BYTES = (MAX_CODE_LEN + 14) / 8;
  localparam int SW        = 8 * MAX_BYTES;
  localparam int TW        = $clog2(SW + 1);
  localparam int BC_W      = $clog2(MAX_BYTES + 1);

  logic              cmd_take;
  logic              res_take;
  logic              is_load;
  logic              is_enc;
  logic              is_fin;
  logic              in_range;
  logic [IDX_W-1:0]  sym_idx;
  logic [LEN_W-1:0]  len_sat;
  logic [2*CODE_W-1:0] ones_sh;
  logic [CODE_W-1:0] code_mask;

  logic [BITS_W-1:0] rd_bits;
  logic [LEN_W-1:0]  rd_len;

  logic              s1_vld;
  logic              s1_fin;
  logic              s1_adv;

  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  acc_cnt;

  logic [TW-1:0]     sum_bits;
  logic [SW-1:0]     stream;
  logic [SW-1:0]     left;
  logic [2:0]        rem;
  logic [BC_W-1:0]   nfull;
  logic [BC_W-1:0]   nbytes;
  logic [ACC_W-1:0]  acc_mask;

  logic [SW-1:0]     eb_word;
  logic [BC_W-1:0]   eb_cnt;
  logic              eb_free;

  // request decode
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign is_load   = (cmd.command == hcbp_pkg::CMD_LOAD);
  assign is_enc    = (cmd.command == hcbp_pkg::CMD_ENCODE);
  assign is_fin    = (cmd.command == hcbp_pkg::CMD_FINISH);
  assign in_range  = (32'(cmd.symbol) < SYMBOL_COUNT);
  assign sym_idx   = IDX_W'(cmd.symbol);
  assign len_sat   = (32'(cmd.code_len) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                        : LEN_W'(cmd.code_len);
  assign ones_sh   = {(2*CODE_W){1'b1}} << len_sat;
  assign code_mask = ~ones_sh[CODE_W-1:0];

  hcbp_code_table #(
    .DEPTH  (SYMBOL_COUNT),
    .IDX_W  (IDX_W),
    .BITS_W (BITS_W),
    .LEN_W  (LEN_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_take && is_load && in_range),
    .wr_idx  (sym_idx),
    .wr_bits (BITS_W'(cmd.code_bits & code_mask)),
    .wr_len  (len_sat),
    .rd_en   (cmd_take && (is_enc || is_fin)),
    .rd_ok   (is_fin || in_range),
    .rd_idx  (is_fin ? '0 : sym_idx),
    .rd_bits (rd_bits),
    .rd_len  (rd_len)
  );

  // append stored code to pending bits
  assign sum_bits = TW'(acc_cnt) + TW'(rd_len);
  assign stream   = (SW'(acc) << rd_len) | SW'(rd_bits);
  assign left     = stream << (TW'(SW) - sum_bits);
  assign rem      = sum_bits[2:0];
  assign nfull    = BC_W'(sum_bits >> 3);
  assign nbytes   = (s1_fin && (rem != 3'd0)) ? nfull + BC_W'(1) : nfull;
  assign acc_mask = ~({ACC_W{1'b1}} << rem);

  assign res_valid = (eb_cnt != '0);
  assign res_take  = res_valid && !res_stall;
  assign eb_free   = (eb_cnt == '0) || ((eb_cnt == BC_W'(1)) && res_take);
  assign s1_adv    = s1_vld && ((nbytes == '0) || eb_free);
  assign cmd_stall = s1_vld && !s1_adv;

  assign res.out_byte  = eb_word[SW-1 -: 8];
  assign res.last_byte = (eb_cnt == BC_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s1_fin  <= 1'b0;
      acc     <= '0;
      acc_cnt <= '0;
      eb_cnt  <= '0;
    end else begin
      if (cmd_take) begin
        s1_vld <= is_enc || is_fin;
        s1_fin <= is_fin;
      end else if (s1_adv) begin
        s1_vld <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_fin) begin
          acc     <= '0;
          acc_cnt <= '0;
        end else begin
          acc     <= ACC_W'(stream) & acc_mask;
          acc_cnt <= rem;
        end
      end
      if (s1_adv && (nbytes != '0)) begin
        eb_cnt <= nbytes;
      end else if (res_take) begin
        eb_cnt <= eb_cnt - BC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (nbytes != '0)) begin
      eb_word <= left;
    end else if (res_take) begin
      eb_word <= eb_word << 8;
    end
  end

`ifndef SYNTHESIS
  a_more_bytes_follow: assert property (@(posedge clk) disable iff (rst)
    res_take && !res.last_byte |=> res_valid)
    else $error("byte run ended before its last byte");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_fin |=> (acc_cnt == '0) && (acc == '0))
    else $error("accumulator not cleared after finish");

  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc >> acc_cnt) == '0)
    else $error("stale bits above pending count");
`endif

endmodule
